// ===== rtl/kcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kcd_pkg;

  localparam int unsigned BUFFER_DEPTH       = 256;
  localparam int unsigned DEFAULT_FRAME_SIZE = 64;

  // highest buffer index written, the index sticks here once reached
  localparam logic [7:0] COUNT_LIMIT =
      (BUFFER_DEPTH - 1 > 255) ? 8'd255 : 8'(BUFFER_DEPTH - 1);

  localparam logic [7:0] KISS_FEND      = 8'hC0;
  localparam logic [7:0] KISS_FESC      = 8'hDB;
  localparam logic [7:0] KISS_TFEND     = 8'hDC;
  localparam logic [7:0] KISS_TFESC     = 8'hDD;
  localparam logic [7:0] HANDSHAKE_BYTE = 8'hAA;

  // command bytes and their arguments
  localparam logic [7:0] CMD_UPLINK = 8'h00;
  localparam logic [7:0] CMD_TEST   = 8'h01;
  localparam logic [7:0] CMD_LENGTH = 8'h02;
  localparam logic [7:0] CMD_TX     = 8'h03;
  localparam logic [7:0] CMD_IDLE   = 8'h04;
  localparam logic [7:0] ARG_ON     = 8'h01;
  localparam logic [7:0] ARG_OFF    = 8'h00;

  typedef struct packed {
    logic        buf_write;
    logic [7:0]  buf_index;
    logic [7:0]  buf_data;
    logic        frame_ready;
    logic [7:0]  frame_length;
    logic        transmitter_on;
    logic        idle_enabled;
    logic [15:0] frame_size;
    logic        reply_valid;
    logic [7:0]  reply_byte;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/kcd_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface kcd_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/kcd_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface kcd_out_if;
  logic        valid;
  logic        ready;
  logic        buf_write;
  logic [7:0]  buf_index;
  logic [7:0]  buf_data;
  logic        frame_ready;
  logic [7:0]  frame_length;
  logic        transmitter_on;
  logic        idle_enabled;
  logic [15:0] frame_size;
  logic        reply_valid;
  logic [7:0]  reply_byte;
  logic        last;

  modport source (
    output valid, output buf_write, output buf_index, output buf_data,
    output frame_ready, output frame_length, output transmitter_on,
    output idle_enabled, output frame_size, output reply_valid,
    output reply_byte, output last, input ready
  );
  modport sink (
    input valid, input buf_write, input buf_index, input buf_data,
    input frame_ready, input frame_length, input transmitter_on,
    input idle_enabled, input frame_size, input reply_valid,
    input reply_byte, input last, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/kcd_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kcd_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic            func,
  input  wire logic [7:0]      rx_byte,
  output kcd_pkg::result_t     res
);

  typedef enum logic [2:0] {
    M_CMD, M_DATA, M_ESC, M_DRAIN, M_LEN_LO, M_LEN_HI, M_TX, M_IDLE
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic        ready_r, ready_nxt;
  logic        tx_r, tx_nxt;
  logic        idle_r, idle_nxt;
  logic [15:0] size_r, size_nxt;

  logic       wr;
  logic [7:0] ub;
  logic       rv;
  logic       lst;

  always_comb begin
    mode_nxt   = mode_r;
    len_lo_nxt = len_lo_r;
    cnt_nxt    = cnt_r;
    ready_nxt  = ready_r;
    tx_nxt     = tx_r;
    idle_nxt   = idle_r;
    size_nxt   = size_r;
    wr         = 1'b0;
    ub         = rx_byte;
    rv         = 1'b0;
    lst        = 1'b1;
    if (func) begin
      ready_nxt = 1'b0;
    end else begin
      unique case (mode_r)
        M_CMD: begin
          if (rx_byte == kcd_pkg::KISS_FEND) begin
            ready_nxt = 1'b0;
            cnt_nxt   = 8'd0;
          end else begin
            case (rx_byte)
              kcd_pkg::CMD_UPLINK: mode_nxt = M_DATA;
              kcd_pkg::CMD_TEST:   mode_nxt = M_DRAIN;
              kcd_pkg::CMD_LENGTH: mode_nxt = M_LEN_LO;
              kcd_pkg::CMD_TX:     mode_nxt = M_TX;
              kcd_pkg::CMD_IDLE:   mode_nxt = M_IDLE;
              default:             mode_nxt = M_CMD;
            endcase
          end
        end
        M_DATA: begin
          if (rx_byte == kcd_pkg::KISS_FEND) begin
            ready_nxt = 1'b1;
            mode_nxt  = M_CMD;
          end else if (rx_byte == kcd_pkg::KISS_FESC) begin
            mode_nxt = M_ESC;
          end else begin
            wr = 1'b1;
          end
        end
        M_ESC: begin
          // a bad escape stores the byte as it came
          if (rx_byte == kcd_pkg::KISS_TFESC) begin
            ub = kcd_pkg::KISS_FESC;
          end else if (rx_byte == kcd_pkg::KISS_TFEND) begin
            ub = kcd_pkg::KISS_FEND;
          end
          wr       = 1'b1;
          mode_nxt = M_DATA;
        end
        M_DRAIN: begin
          if (rx_byte == kcd_pkg::KISS_FEND) begin
            mode_nxt = M_CMD;
            rv       = 1'b1;
            lst      = 1'b0;
          end
        end
        M_LEN_LO: begin
          len_lo_nxt = rx_byte;
          mode_nxt   = M_LEN_HI;
        end
        M_LEN_HI: begin
          size_nxt = {rx_byte, len_lo_r};
          mode_nxt = M_CMD;
        end
        M_TX: begin
          tx_nxt   = (rx_byte == kcd_pkg::ARG_ON);
          mode_nxt = M_CMD;
        end
        M_IDLE: begin
          if (rx_byte == kcd_pkg::ARG_ON) begin
            idle_nxt = 1'b1;
          end else if (rx_byte == kcd_pkg::ARG_OFF) begin
            idle_nxt = 1'b0;
          end
          mode_nxt = M_CMD;
        end
      endcase
      if (wr && (cnt_r < kcd_pkg::COUNT_LIMIT)) begin
        cnt_nxt = cnt_r + 8'd1;
      end
    end
  end

  always_comb begin
    res.buf_write      = wr;
    res.buf_index      = wr ? cnt_r : 8'd0;
    res.buf_data       = wr ? ub : 8'd0;
    res.frame_ready    = ready_nxt;
    res.frame_length   = cnt_nxt;
    res.transmitter_on = tx_nxt;
    res.idle_enabled   = idle_nxt;
    res.frame_size     = size_nxt;
    res.reply_valid    = rv;
    res.reply_byte     = rv ? kcd_pkg::KISS_FEND : 8'd0;
    res.last           = lst;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_CMD;
      len_lo_r <= 8'd0;
      cnt_r    <= 8'd0;
      ready_r  <= 1'b0;
      tx_r     <= 1'b0;
      idle_r   <= 1'b0;
      size_r   <= 16'(kcd_pkg::DEFAULT_FRAME_SIZE);
    end else if (step) begin
      mode_r   <= mode_nxt;
      len_lo_r <= len_lo_nxt;
      cnt_r    <= cnt_nxt;
      ready_r  <= ready_nxt;
      tx_r     <= tx_nxt;
      idle_r   <= idle_nxt;
      size_r   <= size_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kiss_command_deframer_top.sv =====
// KISS command deframer: takes one host byte (or a frame-taken notice) per beat
// on in_ch and gives one result beat per input on out_ch, three for the FEND
// that closes a test command (FEND, 0xAA, FEND). With out_ch always ready the
// block sustains one input per cycle; the test reply occupies the result
// register for three beats, and the next input waits until its last beat is
// taken. Each input passes the input register, then the result register;
// having both also lets one byte be taken while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module kiss_command_deframer_top (
  input  wire logic clk,
  input  wire logic rst_n,
  kcd_in_if.sink    in_ch,
  kcd_out_if.source out_ch
);

  logic             in_full_r;
  logic             in_func_r;
  logic [7:0]       in_byte_r;
  logic             out_valid_r;
  kcd_pkg::result_t out_res_r;
  logic [1:0]       rem_r;

  kcd_pkg::result_t res;
  logic             out_pop;
  logic             load_ok;
  logic             step;

  assign out_pop = out_valid_r && out_ch.ready;
  assign load_ok = !out_valid_r || (out_pop && (rem_r == 2'd0));
  assign step    = in_full_r && load_ok;

  // no beat is taken while reset is held
  assign in_ch.ready = rst_n && (!in_full_r || step);

  kcd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .func    (in_func_r),
    .rx_byte (in_byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_full_r <= 1'b1;
    end else if (step) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_func_r <= in_ch.func;
      in_byte_r <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rem_r       <= 2'd0;
    end else if (step) begin
      out_valid_r <= 1'b1;
      rem_r       <= res.reply_valid ? 2'd2 : 2'd0;
    end else if (out_pop) begin
      if (rem_r != 2'd0) begin
        rem_r <= rem_r - 2'd1;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // remaining reply beats reuse the held status, only the byte and last mark change
  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end else if (out_pop && (rem_r != 2'd0)) begin
      out_res_r.reply_byte <= (rem_r == 2'd2) ? kcd_pkg::HANDSHAKE_BYTE
                                              : kcd_pkg::KISS_FEND;
      out_res_r.last       <= (rem_r == 2'd1);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.buf_write      = out_res_r.buf_write;
  assign out_ch.buf_index      = out_res_r.buf_index;
  assign out_ch.buf_data       = out_res_r.buf_data;
  assign out_ch.frame_ready    = out_res_r.frame_ready;
  assign out_ch.frame_length   = out_res_r.frame_length;
  assign out_ch.transmitter_on = out_res_r.transmitter_on;
  assign out_ch.idle_enabled   = out_res_r.idle_enabled;
  assign out_ch.frame_size     = out_res_r.frame_size;
  assign out_ch.reply_valid    = out_res_r.reply_valid;
  assign out_ch.reply_byte     = out_res_r.reply_byte;
  assign out_ch.last           = out_res_r.last;

endmodule

`default_nettype wire

// ===== rtl/kcd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kcd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_buf_write,
  input wire logic [7:0] out_buf_index,
  input wire logic [7:0] out_buf_data,
  input wire logic       out_reply_valid,
  input wire logic [7:0] out_reply_byte,
  input wire logic       out_last
);

  // a stalled beat stays up
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  // a stalled beat keeps its reply byte and last mark
  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_reply_byte) && $stable(out_last))
    else $error("out payload changed while stalled");

  // a buffer write and a reply byte never share a beat
  a_write_or_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_buf_write && out_reply_valid))
    else $error("buffer write and reply in one beat");

  // only the test reply spans beats, and it closes on FEND
  a_reply_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!out_last || (out_reply_valid && out_last)) |->
      out_reply_valid && (out_last ? (out_reply_byte == kcd_pkg::KISS_FEND) : 1'b1))
    else $error("multi-beat result is not a proper reply frame");

  // unused payload fields read as zero
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_buf_write || (out_buf_index == 8'd0 && out_buf_data == 8'd0))
                  && (out_reply_valid || out_reply_byte == 8'd0))
    else $error("unused payload field is not zero");

endmodule

bind kiss_command_deframer_top kcd_checker u_kcd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_buf_write   (out_ch.buf_write),
  .out_buf_index   (out_ch.buf_index),
  .out_buf_data    (out_ch.buf_data),
  .out_reply_valid (out_ch.reply_valid),
  .out_reply_byte  (out_ch.reply_byte),
  .out_last        (out_ch.last)
);

`default_nettype wire

// ===== tb/sv/kiss_command_deframer_top_test.sv =====
`timescale 1ns / 1ps

module kiss_command_deframer_top_test;

  localparam logic FUNC_BYTE  = 1'b0;
  localparam logic FUNC_TAKEN = 1'b1;

  localparam logic [7:0] CMD_UNKNOWN = 8'h05;

  typedef enum logic [2:0] {
    PM_COMMAND, PM_DATA, PM_ESCAPE, PM_DRAIN,
    PM_LEN_LO, PM_LEN_HI, PM_TRANSMIT, PM_IDLE
  } parse_mode_t;

  logic clk;
  logic rst_n;
  logic stall_on;
  int   mismatch_count;
  int   items_sent;

  kcd_in_if  in_ch ();
  kcd_out_if out_ch ();

  kiss_command_deframer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // deframer state as the host side sees it
  parse_mode_t m_mode;
  logic [7:0]  m_len_lo;
  logic [7:0]  m_count;
  logic        m_ready;
  logic        m_tx;
  logic        m_idle;
  logic [15:0] m_size;

  kcd_pkg::result_t results_due[$];

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic void push_result(input logic wr, input logic [7:0] idx,
                                      input logic [7:0] data, input logic rv,
                                      input logic [7:0] rb, input logic lst);
    kcd_pkg::result_t r;
    r.buf_write      = wr;
    r.buf_index      = idx;
    r.buf_data       = data;
    r.frame_ready    = m_ready;
    r.frame_length   = m_count;
    r.transmitter_on = m_tx;
    r.idle_enabled   = m_idle;
    r.frame_size     = m_size;
    r.reply_valid    = rv;
    r.reply_byte     = rb;
    r.last           = lst;
    results_due.push_back(r);
  endfunction

  function automatic void buffer_byte(input logic [7:0] v, output logic wr,
                                      output logic [7:0] idx, output logic [7:0] data);
    wr   = 1'b1;
    idx  = m_count;
    data = v;
    if (m_count < kcd_pkg::COUNT_LIMIT) m_count = m_count + 8'd1;
  endfunction

  function automatic void decode_host_byte(input logic f, input logic [7:0] b);
    logic       wr;
    logic [7:0] idx;
    logic [7:0] data;
    logic [7:0] v;
    wr   = 1'b0;
    idx  = '0;
    data = '0;
    v    = b;
    if (f == FUNC_TAKEN) begin
      m_ready = 1'b0;
      push_result(1'b0, '0, '0, 1'b0, '0, 1'b1);
      return;
    end
    case (m_mode)
      PM_COMMAND: begin
        if (b == kcd_pkg::KISS_FEND) begin
          m_ready = 1'b0;
          m_count = '0;
        end else if (b == kcd_pkg::CMD_UPLINK) begin
          m_mode = PM_DATA;
        end else if (b == kcd_pkg::CMD_TEST) begin
          m_mode = PM_DRAIN;
        end else if (b == kcd_pkg::CMD_LENGTH) begin
          m_mode = PM_LEN_LO;
        end else if (b == kcd_pkg::CMD_TX) begin
          m_mode = PM_TRANSMIT;
        end else if (b == kcd_pkg::CMD_IDLE) begin
          m_mode = PM_IDLE;
        end
      end
      PM_DATA: begin
        if (b == kcd_pkg::KISS_FEND) begin
          m_ready = 1'b1;
          m_mode  = PM_COMMAND;
        end else if (b == kcd_pkg::KISS_FESC) begin
          m_mode = PM_ESCAPE;
        end else begin
          buffer_byte(v, wr, idx, data);
        end
      end
      PM_ESCAPE: begin
        // a bad escape stores the byte as it came
        if (b == kcd_pkg::KISS_TFESC) v = kcd_pkg::KISS_FESC;
        else if (b == kcd_pkg::KISS_TFEND) v = kcd_pkg::KISS_FEND;
        buffer_byte(v, wr, idx, data);
        m_mode = PM_DATA;
      end
      PM_DRAIN: begin
        if (b == kcd_pkg::KISS_FEND) begin
          m_mode = PM_COMMAND;
          push_result(1'b0, '0, '0, 1'b1, kcd_pkg::KISS_FEND, 1'b0);
          push_result(1'b0, '0, '0, 1'b1, kcd_pkg::HANDSHAKE_BYTE, 1'b0);
          push_result(1'b0, '0, '0, 1'b1, kcd_pkg::KISS_FEND, 1'b1);
          return;
        end
      end
      PM_LEN_LO: begin
        m_len_lo = b;
        m_mode   = PM_LEN_HI;
      end
      PM_LEN_HI: begin
        m_size = {b, m_len_lo};
        m_mode = PM_COMMAND;
      end
      PM_TRANSMIT: begin
        m_tx   = (b == kcd_pkg::ARG_ON);
        m_mode = PM_COMMAND;
      end
      default: begin
        if (b == kcd_pkg::ARG_ON) m_idle = 1'b1;
        else if (b == kcd_pkg::ARG_OFF) m_idle = 1'b0;
        m_mode = PM_COMMAND;
      end
    endcase
    push_result(wr, idx, data, 1'b0, '0, 1'b1);
  endfunction

  // entered and left at a falling edge, valid stays high for a following beat
  task automatic send_item(input logic f, input logic [7:0] b);
    while (stall_on && $urandom_range(99) < 38) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.func    = f;
    in_ch.rx_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    decode_host_byte(f, b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(FUNC_BYTE, b);
  endtask

  function automatic logic [7:0] plain_data();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == kcd_pkg::KISS_FEND || b == kcd_pkg::KISS_FESC) b = b ^ 8'h01;
    return b;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(negedge clk) begin
    out_ch.ready = !stall_on || ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin : result_check
    kcd_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        $error("result beat with nothing expected");
        mismatch_count++;
      end else begin
        want = results_due.pop_front();
        check_field("buf_write", 16'(want.buf_write), 16'(out_ch.buf_write));
        check_field("buf_index", 16'(want.buf_index), 16'(out_ch.buf_index));
        check_field("buf_data", 16'(want.buf_data), 16'(out_ch.buf_data));
        check_field("frame_ready", 16'(want.frame_ready), 16'(out_ch.frame_ready));
        check_field("frame_length", 16'(want.frame_length), 16'(out_ch.frame_length));
        check_field("transmitter_on", 16'(want.transmitter_on),
                    16'(out_ch.transmitter_on));
        check_field("idle_enabled", 16'(want.idle_enabled), 16'(out_ch.idle_enabled));
        check_field("frame_size", want.frame_size, out_ch.frame_size);
        check_field("reply_valid", 16'(want.reply_valid), 16'(out_ch.reply_valid));
        check_field("reply_byte", 16'(want.reply_byte), 16'(out_ch.reply_byte));
        check_field("last", 16'(want.last), 16'(out_ch.last));
      end
    end
  end

  task automatic test_frame_clear();
    send_byte(kcd_pkg::KISS_FEND);
    send_item(FUNC_TAKEN, 8'hFF);
  endtask

  task automatic test_uplink_escapes();
    send_byte(kcd_pkg::CMD_UPLINK);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(kcd_pkg::KISS_FESC);
    send_byte(kcd_pkg::KISS_TFEND);
    send_byte(kcd_pkg::KISS_FESC);
    send_byte(kcd_pkg::KISS_TFESC);
    // bad escapes, the second stores FEND without closing the frame
    send_byte(kcd_pkg::KISS_FESC);
    send_byte(8'h41);
    send_byte(kcd_pkg::KISS_FESC);
    send_byte(kcd_pkg::KISS_FEND);
    // frame taken mid-frame, ready still rises at the close
    send_item(FUNC_TAKEN, 8'h00);
    send_byte(kcd_pkg::KISS_FEND);
  endtask

  task automatic test_handshake_reply();
    send_byte(kcd_pkg::CMD_TEST);
    send_byte(8'h55);
    send_byte(kcd_pkg::KISS_FEND);
  endtask

  task automatic test_frame_size();
    send_byte(kcd_pkg::CMD_LENGTH);
    send_byte(kcd_pkg::KISS_FEND);
    send_byte(8'hFF);
  endtask

  task automatic test_transmitter();
    send_byte(kcd_pkg::CMD_TX);
    send_byte(kcd_pkg::ARG_ON);
    send_byte(kcd_pkg::CMD_TX);
    send_byte(kcd_pkg::KISS_FEND);
  endtask

  task automatic test_idle_mode();
    send_byte(kcd_pkg::CMD_IDLE);
    send_byte(kcd_pkg::ARG_ON);
    send_byte(kcd_pkg::CMD_IDLE);
    send_byte(8'h02);
    send_byte(kcd_pkg::CMD_IDLE);
    send_byte(kcd_pkg::ARG_OFF);
  endtask

  task automatic test_unknown_command();
    send_byte(CMD_UNKNOWN);
    send_byte(8'h80);
  endtask

  task automatic test_buffer_saturation();
    int n;
    n = 256 - int'(m_count) + 4;
    send_byte(kcd_pkg::CMD_UPLINK);
    repeat (n) send_byte(plain_data());
    send_byte(kcd_pkg::KISS_FEND);
  endtask

  task automatic send_random_frame();
    int         n;
    logic [7:0] b;
    if ($urandom_range(2) == 0) send_byte(kcd_pkg::KISS_FEND);
    send_byte(kcd_pkg::CMD_UPLINK);
    n = $urandom_range(12);
    repeat (n) begin
      b = 8'($urandom_range(255));
      case ($urandom_range(9))
        0: begin
          send_byte(kcd_pkg::KISS_FESC);
          send_byte($urandom_range(1) ? kcd_pkg::KISS_TFEND : kcd_pkg::KISS_TFESC);
        end
        1: begin
          send_byte(kcd_pkg::KISS_FESC);
          send_byte(b);
        end
        2: send_item(FUNC_TAKEN, b);
        default: send_byte(plain_data());
      endcase
    end
    send_byte(kcd_pkg::KISS_FEND);
  endtask

  task automatic send_random_command();
    int k;
    k = $urandom_range(99);
    if (k < 45) begin
      send_random_frame();
    end else if (k < 55) begin
      send_byte(kcd_pkg::CMD_TEST);
      repeat ($urandom_range(4)) send_byte(8'($urandom_range(255)));
      send_byte(kcd_pkg::KISS_FEND);
    end else if (k < 65) begin
      send_byte(kcd_pkg::CMD_LENGTH);
      send_byte(8'($urandom_range(255)));
      send_byte(8'($urandom_range(255)));
    end else if (k < 73) begin
      send_byte(kcd_pkg::CMD_TX);
      send_byte($urandom_range(1) ? kcd_pkg::ARG_ON : 8'($urandom_range(255)));
    end else if (k < 81) begin
      send_byte(kcd_pkg::CMD_IDLE);
      case ($urandom_range(2))
        0: send_byte(kcd_pkg::ARG_ON);
        1: send_byte(kcd_pkg::ARG_OFF);
        default: send_byte(8'($urandom_range(255)));
      endcase
    end else begin
      send_item(($urandom_range(3) == 0) ? FUNC_TAKEN : FUNC_BYTE,
                8'($urandom_range(255)));
    end
  endtask

  task automatic run_mixed_traffic(input int n);
    int start;
    start = items_sent;
    while (items_sent - start < n) send_random_command();
  endtask

  task automatic test_full_rate_traffic();
    stall_on = 1'b0;
    run_mixed_traffic(60);
    stall_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    run_mixed_traffic(140);
  endtask

  initial begin
    int wait_cycles;
    rst_n          = 1'b0;
    stall_on       = 1'b1;
    mismatch_count = 0;
    items_sent     = 0;
    in_ch.valid    = 1'b0;
    in_ch.func     = FUNC_BYTE;
    in_ch.rx_byte  = '0;
    m_mode   = PM_COMMAND;
    m_len_lo = '0;
    m_count  = '0;
    m_ready  = 1'b0;
    m_tx     = 1'b0;
    m_idle   = 1'b0;
    m_size   = 16'(kcd_pkg::DEFAULT_FRAME_SIZE);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_frame_clear();
    test_uplink_escapes();
    test_handshake_reply();
    test_frame_size();
    test_transmitter();
    test_idle_mode();
    test_unknown_command();
    test_full_rate_traffic();
    test_buffer_saturation();
    test_random_traffic();

    in_ch.valid = 1'b0;
    wait_cycles = 0;
    while (results_due.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d expected result beats never arrived", results_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== kiss_command_deframer_top.f =====
rtl/kcd_pkg.sv
rtl/kcd_in_if.sv
rtl/kcd_out_if.sv
rtl/kcd_parser.sv
rtl/kiss_command_deframer_top.sv
rtl/kcd_checker.sv
tb/sv/kiss_command_deframer_top_test.sv
